### hw/rtl/gnh_pkg.sv
// Shared types, constants and direction-region helpers for the grid next-hop block.
`timescale 1ns / 1ps

package gnh_pkg;

	localparam int GRID_SIDE_DEF = 4;
	localparam int TILE_W        = 4;
	localparam int NUM_TILES     = 1 << TILE_W;
	localparam int COORD_W       = 4;
	localparam int DIFF_W        = COORD_W + 1;

	typedef logic [TILE_W-1:0]         tile_t;
	typedef logic [COORD_W-1:0]        coord_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;

	// Direction regions around the current tile, clockwise from up-left.
	typedef enum logic [3:0] {
		REG_UP_LEFT    = 4'd0,
		REG_UP         = 4'd1,
		REG_UP_RIGHT   = 4'd2,
		REG_RIGHT      = 4'd3,
		REG_DOWN_RIGHT = 4'd4,
		REG_DOWN       = 4'd5,
		REG_DOWN_LEFT  = 4'd6,
		REG_LEFT       = 4'd7,
		REG_NONE       = 4'd8
	} region_t;

	function automatic region_t region_of(diff_t dx, diff_t dy);
		region_t r;
		r = REG_NONE;
		if (dy < 0) begin
			if (dx < 0)       r = REG_UP_LEFT;
			else if (dx == 0) r = REG_UP;
			else              r = REG_UP_RIGHT;
		end else if (dy == 0) begin
			if (dx > 0)       r = REG_RIGHT;
			else if (dx < 0)  r = REG_LEFT;
		end else begin
			if (dx > 0)       r = REG_DOWN_RIGHT;
			else if (dx == 0) r = REG_DOWN;
			else              r = REG_DOWN_LEFT;
		end
		return r;
	endfunction

	// A diagonal target region also conflicts with its two neighboring axis regions.
	function automatic logic regions_conflict(region_t tr, region_t br);
		logic [2:0] t3;
		logic [2:0] b3;
		logic       hit;
		t3  = tr[2:0];
		b3  = br[2:0];
		hit = 1'b0;
		if (tr != REG_NONE && br != REG_NONE) begin
			if (t3 == b3)
				hit = 1'b1;
			else if (!t3[0])
				hit = (b3 == t3 + 3'd1) || (b3 == t3 - 3'd1);
		end
		return hit;
	endfunction

endpackage

### hw/rtl/gnh_route.sv
// Combinational next-hop decision for one current/target/obstacle triple.
`timescale 1ns / 1ps

module gnh_route #(
	parameter int GRID_SIDE = gnh_pkg::GRID_SIDE_DEF
) (
	input  gnh_pkg::tile_t cur,
	input  gnh_pkg::tile_t tgt,
	input  gnh_pkg::tile_t blk,
	output gnh_pkg::tile_t nxt
);

	localparam int NT = gnh_pkg::NUM_TILES;
	localparam gnh_pkg::tile_t SIDE_T = gnh_pkg::TILE_W'(GRID_SIDE);

	// Row and column of every tile index, worked out at elaboration.
	gnh_pkg::coord_t row_tab [NT];
	gnh_pkg::coord_t col_tab [NT];

	for (genvar i = 0; i < NT; i++) begin : g_tab
		assign row_tab[i] = gnh_pkg::COORD_W'(i / GRID_SIDE);
		assign col_tab[i] = gnh_pkg::COORD_W'(i % GRID_SIDE);
	end

	gnh_pkg::coord_t cx, cy, tx, ty, bx, by;
	gnh_pkg::diff_t  dx, dy, bdx, bdy;
	gnh_pkg::coord_t ax, ay, abx, aby;
	gnh_pkg::coord_t x_toward, y_toward;
	gnh_pkg::coord_t nx, ny;
	gnh_pkg::tile_t  row_base;
	logic            conflict;

	assign cx = col_tab[cur];
	assign cy = row_tab[cur];
	assign tx = col_tab[tgt];
	assign ty = row_tab[tgt];
	assign bx = col_tab[blk];
	assign by = row_tab[blk];

	assign dx  = gnh_pkg::diff_t'({1'b0, tx}) - gnh_pkg::diff_t'({1'b0, cx});
	assign dy  = gnh_pkg::diff_t'({1'b0, ty}) - gnh_pkg::diff_t'({1'b0, cy});
	assign bdx = gnh_pkg::diff_t'({1'b0, bx}) - gnh_pkg::diff_t'({1'b0, cx});
	assign bdy = gnh_pkg::diff_t'({1'b0, by}) - gnh_pkg::diff_t'({1'b0, cy});

	assign ax  = dx[gnh_pkg::DIFF_W-1]  ? gnh_pkg::COORD_W'(-dx)  : gnh_pkg::COORD_W'(dx);
	assign ay  = dy[gnh_pkg::DIFF_W-1]  ? gnh_pkg::COORD_W'(-dy)  : gnh_pkg::COORD_W'(dy);
	assign abx = bdx[gnh_pkg::DIFF_W-1] ? gnh_pkg::COORD_W'(-bdx) : gnh_pkg::COORD_W'(bdx);
	assign aby = bdy[gnh_pkg::DIFF_W-1] ? gnh_pkg::COORD_W'(-bdy) : gnh_pkg::COORD_W'(bdy);

	// One step toward the target on each axis; only used where that distance is nonzero.
	assign x_toward = dx[gnh_pkg::DIFF_W-1] ? cx - 1'b1 : cx + 1'b1;
	assign y_toward = dy[gnh_pkg::DIFF_W-1] ? cy - 1'b1 : cy + 1'b1;

	assign conflict = gnh_pkg::regions_conflict(gnh_pkg::region_of(dx, dy),
	                                             gnh_pkg::region_of(bdx, bdy));

	always_comb begin
		nx = cx;
		ny = cy;
		if (ax == 4'd1 && dy == 0) begin
			nx = x_toward;
		end else if (ay == 4'd1 && dx == 0) begin
			ny = y_toward;
		end else if (conflict && abx == 4'd1 && aby == 4'd1) begin
			if (ax > ay) nx = x_toward;
			else         ny = y_toward;
		end else if (conflict && abx == 4'd1 && aby == 4'd0) begin
			// Blocker beside us in the row: step toward the target row, else sidestep down from the top row and up elsewhere.
			if (dy != 0)      ny = y_toward;
			else if (cy == 0) ny = cy + 1'b1;
			else              ny = cy - 1'b1;
		end else if (conflict && abx == 4'd0 && aby == 4'd1) begin
			if (dx != 0)      nx = x_toward;
			else if (cx == 0) nx = cx + 1'b1;
			else              nx = cx - 1'b1;
		end else if (dx != 0 && dy != 0) begin
			if (ax <= ay) nx = x_toward;
			else          ny = y_toward;
		end else if (dx == 0) begin
			ny = y_toward;
		end else begin
			nx = x_toward;
		end
	end

	// The index wraps to four bits, so the product is kept modulo sixteen.
	assign row_base = gnh_pkg::TILE_W'(ny * SIDE_T);

	assign nxt = (tgt == blk || tgt == cur) ? cur : gnh_pkg::tile_t'(row_base + nx);

endmodule

### hw/rtl/grid_next_hop_with_obstacle.sv
// Top level of the grid next-hop block: input register, decision logic, result register.
`timescale 1ns / 1ps

// Takes one request (current, target and blocked tile, row-major on a GRID_SIDE square
// grid) per clock while in_stall is low and returns the adjacent tile to move to, or the
// current tile when it stays. A new request is taken before earlier ones have left; each
// result is held in the input register and then in the result register. out_stall
// reaches in_stall combinationally through the two stage enables, so a full pipeline
// holds its input while the result is not taken and an empty stage always accepts.

module grid_next_hop_with_obstacle #(
	parameter int GRID_SIDE = gnh_pkg::GRID_SIDE_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  gnh_pkg::tile_t current_tile,
	input  gnh_pkg::tile_t target_tile,
	input  gnh_pkg::tile_t obstacle_tile,
	output logic           out_valid,
	input  logic           out_stall,
	output gnh_pkg::tile_t next_tile
);

	logic           valid_s1;
	gnh_pkg::tile_t cur_s1, tgt_s1, blk_s1;
	gnh_pkg::tile_t hop;
	logic           load_out;
	logic           load_s1;

	assign load_out = !out_valid || !out_stall;
	assign load_s1  = !valid_s1 || load_out;
	assign in_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			cur_s1 <= current_tile;
			tgt_s1 <= target_tile;
			blk_s1 <= obstacle_tile;
		end
	end

	gnh_route #(
		.GRID_SIDE(GRID_SIDE)
	) u_route (
		.cur(cur_s1),
		.tgt(tgt_s1),
		.blk(blk_s1),
		.nxt(hop)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out && valid_s1) begin
			next_tile <= hop;
		end
	end

	a_empty_stage_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("input stage empty but input stalled");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !load_out |=> valid_s1 && $stable(cur_s1) && $stable(tgt_s1)
			&& $stable(blk_s1))
		else $error("input stage lost its item while the result register was full");

	a_stay_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && load_out && (tgt_s1 == blk_s1 || tgt_s1 == cur_s1)
			|=> out_valid && next_tile == $past(cur_s1))
		else $error("blocked or reached target did not return the current tile");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !valid_s1 |=> !out_valid)
		else $error("result repeated after its transfer");

endmodule
